### design/nbd_pkg.sv
`default_nettype none

package nbd_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_name;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
    logic [1:0] error_kind;
  } out_item_t;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_BAD_CHAR = 2'd1;
  localparam logic [1:0] ERR_ODD_CHAR = 2'd2;
  localparam logic [1:0] ERR_TOO_LONG = 2'd3;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_LT    = 8'h3C;
  localparam logic [7:0] CHAR_GT    = 8'h3E;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_P     = 8'h41 + 8'd15;
  localparam logic [7:0] CHAR_DEL   = 8'h7F;
  localparam logic [3:0] NIB_MASK   = 4'h0F;

  localparam logic [7:0] HEX_DIGITS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    return HEX_DIGITS[nib];
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  // not printable, or a space
  function automatic logic needs_marker(input logic [7:0] c);
    return (c <= CHAR_SPACE) || (c >= CHAR_DEL);
  endfunction

endpackage

`default_nettype wire

### design/nbd_store.sv
`default_nettype none

module nbd_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### design/nbd_seq.sv
`default_nettype none

module nbd_seq #(
  parameter int NAME_BYTES = 16,
  parameter int AW         = 4,
  parameter int CW         = 5
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire nbd_pkg::in_item_t item,
  input  wire logic              slot_free,
  output logic                   emit_valid,
  output nbd_pkg::out_item_t     emit_data,
  output logic                   mem_rd_en,
  output logic [AW-1:0]          mem_rd_addr,
  output logic                   mem_wr_en,
  output logic [AW-1:0]          mem_wr_addr,
  output logic [7:0]             mem_wr_data,
  input  wire logic [7:0]        mem_rd_data
);

  import nbd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_TRIM, S_BYTES, S_MARK, S_TAIL
  } state_t;

  state_t      state;
  logic [CW-1:0] byte_count;
  logic [3:0]  high_nibble;
  logic        half_pending;
  logic        in_scope;
  logic [1:0]  first_error;
  logic [7:0]  trail_char;
  logic        trail_last;
  logic [7:0]  code;
  logic        mark_en;
  logic [1:0]  mark_idx;
  logic [CW-1:0] end_cnt;
  logic [CW-1:0] idx;

  logic          accept;
  logic          term;
  logic          flush;
  logic          name_char;
  logic          bad_char;
  logic [3:0]    nib;
  logic          room;
  logic [CW-1:0] bc_m1;
  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] cnt_m2;
  logic [CW-1:0] idx_p1;
  logic [1:0]    err_flush;
  logic [1:0]    err_name;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign term       = item.end_of_name || (item.char_code == CHAR_NUL);
  assign flush      = !in_scope && (term || (item.char_code == CHAR_DOT));
  assign name_char  = !term && !in_scope && (item.char_code != CHAR_DOT);
  assign bad_char   = (item.char_code < CHAR_A) || (item.char_code > CHAR_P);
  assign nib        = (item.char_code[3:0] - 4'd1) & NIB_MASK;
  assign room       = byte_count < CW'(NAME_BYTES);
  assign bc_m1      = byte_count - CW'(1);
  assign cnt_m1     = end_cnt - CW'(1);
  assign cnt_m2     = end_cnt - CW'(2);
  assign idx_p1     = idx + CW'(1);

  always_comb begin
    err_flush = first_error;
    if (first_error == ERR_NONE && half_pending) begin
      err_flush = ERR_ODD_CHAR;
    end
    err_name = first_error;
    if (first_error == ERR_NONE) begin
      if (bad_char) begin
        err_name = ERR_BAD_CHAR;
      end else if (half_pending && !room) begin
        err_name = ERR_TOO_LONG;
      end
    end
  end

  // memory port control; writes happen only in idle, reads only while flushing
  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = byte_count[AW-1:0];
    mem_wr_data = {high_nibble, nib};
    unique case (state)
      S_IDLE: begin
        if (accept && flush && byte_count != '0) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = bc_m1[AW-1:0];
        end
        if (accept && name_char && half_pending && room) begin
          mem_wr_en = 1'b1;
        end
      end
      S_CHECK: begin
        if (needs_marker(mem_rd_data)) begin
          if (end_cnt != '0) begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = cnt_m1[AW-1:0];
          end
        end else begin
          mem_rd_en = 1'b1;
        end
      end
      S_TRIM: begin
        if (is_ws(mem_rd_data)) begin
          if (cnt_m1 != '0) begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = cnt_m2[AW-1:0];
          end
        end else begin
          mem_rd_en = 1'b1;
        end
      end
      S_BYTES: begin
        if (slot_free && idx_p1 < end_cnt) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = idx_p1[AW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    emit_valid           = 1'b0;
    emit_data.out_char   = trail_char;
    emit_data.last       = 1'b0;
    emit_data.error_kind = first_error;
    unique case (state)
      S_BYTES: begin
        emit_valid         = slot_free;
        emit_data.out_char = mem_rd_data;
      end
      S_MARK: begin
        emit_valid = slot_free;
        unique case (mark_idx)
          2'd0:    emit_data.out_char = CHAR_LT;
          2'd1:    emit_data.out_char = hex_digit(code[7:4]);
          2'd2:    emit_data.out_char = hex_digit(code[3:0]);
          default: emit_data.out_char = CHAR_GT;
        endcase
      end
      S_TAIL: begin
        emit_valid     = slot_free;
        emit_data.last = trail_last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      byte_count   <= '0;
      high_nibble  <= '0;
      half_pending <= 1'b0;
      in_scope     <= 1'b0;
      first_error  <= ERR_NONE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            trail_char <= term ? CHAR_NUL : item.char_code;
            trail_last <= term;
            mark_en    <= 1'b0;
            mark_idx   <= '0;
            idx        <= '0;
            end_cnt    <= bc_m1;
            if (flush) begin
              first_error  <= err_flush;
              half_pending <= 1'b0;
              state        <= (byte_count == '0) ? S_TAIL : S_CHECK;
            end else if (!name_char) begin
              state <= S_TAIL;
            end else begin
              first_error <= err_name;
              if (!half_pending) begin
                high_nibble  <= nib;
                half_pending <= 1'b1;
              end else begin
                half_pending <= 1'b0;
                if (room) begin
                  byte_count <= byte_count + CW'(1);
                end
              end
            end
          end
        end
        S_CHECK: begin
          code <= mem_rd_data;
          if (needs_marker(mem_rd_data)) begin
            mark_en <= 1'b1;
            state   <= (end_cnt == '0) ? S_MARK : S_TRIM;
          end else begin
            end_cnt <= byte_count;
            state   <= S_BYTES;
          end
        end
        S_TRIM: begin
          if (is_ws(mem_rd_data)) begin
            end_cnt <= cnt_m1;
            if (cnt_m1 == '0) begin
              state <= S_MARK;
            end
          end else begin
            state <= S_BYTES;
          end
        end
        S_BYTES: begin
          if (slot_free) begin
            idx <= idx_p1;
            if (idx_p1 >= end_cnt) begin
              state <= mark_en ? S_MARK : S_TAIL;
            end
          end
        end
        S_MARK: begin
          if (slot_free) begin
            mark_idx <= mark_idx + 2'd1;
            if (mark_idx == 2'd3) begin
              state <= S_TAIL;
            end
          end
        end
        S_TAIL: begin
          if (slot_free) begin
            byte_count <= '0;
            state      <= S_IDLE;
            if (trail_last) begin
              high_nibble  <= '0;
              half_pending <= 1'b0;
              in_scope     <= 1'b0;
              first_error  <= ERR_NONE;
            end else begin
              in_scope <= 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(mem_rd_en && mem_wr_en))
    else $error("store read and write in the same cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CW'(NAME_BYTES))
    else $error("byte count beyond name length");

  a_bytes_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_BYTES) |-> (idx < end_cnt))
    else $error("byte index past end of flush");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (emit_valid && emit_data.last) |=>
      (state == S_IDLE && byte_count == '0 && first_error == ERR_NONE && !in_scope))
    else $error("state not cleared after terminator");

endmodule

`default_nettype wire

### design/netbios_name_decoder_core.sv
// netbios name decoder
// input channel item_valid/item_ready/item carries one encoded character per
// transaction, or an end of name marker (end_of_name set, or a nul character).
// output channel result_valid/result_ready/result carries one decoded byte per
// transaction; the transaction with last set carries the zero terminator.
// name characters before the first dot are taken one per cycle and give no
// result; pairs of them are decoded into bytes and written to a single-port
// style store of NAME_BYTES entries with a registered read. a scope
// character's result is emitted from the tail state, so scope characters
// are not taken back to back. at the dot or at the end of a name the store
// is read back: the last byte is checked first, then each byte examined
// while trimming whitespace (the trimmed ones and the byte that stops the
// trim), then the emitted bytes and a four-character hex marker; the dot or
// terminator follows. a new transaction is taken once the last result of
// the previous one sits in the output register. a stalled receiver holds
// the result register and the sequencer waits. synchronous reset clears the
// state, byte count, nibble, scope and error; the store needs no clearing.
`default_nettype none

module netbios_name_decoder_core #(
  parameter int NAME_BYTES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire nbd_pkg::in_item_t  item,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output nbd_pkg::out_item_t      result
);

  import nbd_pkg::*;

  localparam int AW = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
  localparam int CW = $clog2(NAME_BYTES + 1);

  logic          slot_free;
  logic          emit_valid;
  out_item_t     emit_data;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [7:0]    mem_wr_data;
  logic [7:0]    mem_rd_data;

  assign slot_free = !result_valid || result_ready;

  nbd_store #(
    .DEPTH (NAME_BYTES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_data (mem_rd_data)
  );

  nbd_seq #(
    .NAME_BYTES (NAME_BYTES),
    .AW         (AW),
    .CW         (CW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .slot_free   (slot_free),
    .emit_valid  (emit_valid),
    .emit_data   (emit_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_data (mem_rd_data)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_valid) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid) begin
      result <= emit_data;
    end
  end

endmodule

`default_nettype wire
